// ===== sv/dtq_pkg.sv =====
// Shared constants, command and status types for the delta-list timer queue.
`default_nettype none

package dtq_pkg;

    localparam int NUM_UNITS  = 16;
    localparam int IDX_BITS   = $clog2(NUM_UNITS);
    localparam int UNIT_BITS  = IDX_BITS + 1;
    localparam int TIME_BITS  = 32;
    localparam int ACC_BITS   = TIME_BITS + UNIT_BITS;
    localparam int CNT_BITS   = UNIT_BITS;
    localparam int UNTIL_BITS = 31;
    localparam int DELAY_BITS = 31;
    localparam int TICK_BITS  = 16;

    localparam logic [UNIT_BITS-1:0]  END_MARK  = UNIT_BITS'(NUM_UNITS);
    localparam logic [CNT_BITS-1:0]   CNT_LIMIT = CNT_BITS'(NUM_UNITS);
    localparam logic [UNTIL_BITS-1:0] UNTIL_MAX = {UNTIL_BITS{1'b1}};

    localparam logic [1:0] OP_ACTIVATE = 2'd0;
    localparam logic [1:0] OP_CANCEL   = 2'd1;
    localparam logic [1:0] OP_ADVANCE  = 2'd2;
    localparam logic [1:0] OP_QUERY    = 2'd3;

    localparam logic [2:0] SEL_CUR   = 3'd0;
    localparam logic [2:0] SEL_HEAD  = 3'd1;
    localparam logic [2:0] SEL_NHEAD = 3'd2;
    localparam logic [2:0] SEL_UNIT  = 3'd3;
    localparam logic [2:0] SEL_NX    = 3'd4;

    typedef struct packed {
        logic [2:0] sel;
        logic       load;
        logic       act_step;
        logic       act_link;
        logic       act_fix;
        logic       can_start;
        logic       can_link;
        logic       can_step;
        logic       can_fix;
        logic       qry_step;
        logic       qry_miss;
        logic       adv_start;
        logic       adv_fire;
    } cmd_t;

    typedef struct packed {
        logic unit_queued;
        logic head_valid;
        logic head_is_u;
        logic cur_valid;
        logic act_stop;
        logic link_hit;
        logic qry_hit;
        logic adv_hold;
        logic adv_last;
    } stat_t;

endpackage

`default_nettype wire

// ===== sv/dtq_ctrl.sv =====
// Controller state machine sequencing each command word over the list walk.
`default_nettype none

module dtq_ctrl
    import dtq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] opcode,
    input  wire stat_t      stat,
    output cmd_t            cmd,
    output logic            busy
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_ACT_WALK  = 4'd1;
    localparam logic [3:0] S_ACT_FIX   = 4'd2;
    localparam logic [3:0] S_CAN_START = 4'd3;
    localparam logic [3:0] S_CAN_WALK  = 4'd4;
    localparam logic [3:0] S_CAN_FIX   = 4'd5;
    localparam logic [3:0] S_QRY_WALK  = 4'd6;
    localparam logic [3:0] S_ADV_START = 4'd7;
    localparam logic [3:0] S_ADV_FIRE  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.sel    = SEL_CUR;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    case (opcode)
                        OP_ACTIVATE: state_next = S_ACT_WALK;
                        OP_CANCEL:   state_next = S_CAN_START;
                        OP_ADVANCE:  state_next = S_ADV_START;
                        default:     state_next = S_QRY_WALK;
                    endcase
                end
            end
            S_ACT_WALK:
            begin
                if (stat.unit_queued)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.cur_valid && !stat.act_stop)
                begin
                    cmd.act_step = 1'b1;
                end
                else
                begin
                    cmd.act_link = 1'b1;
                    state_next   = S_ACT_FIX;
                end
            end
            S_ACT_FIX:
            begin
                cmd.act_fix = 1'b1;
                state_next  = S_IDLE;
            end
            S_CAN_START:
            begin
                cmd.sel = SEL_UNIT;
                if (!stat.unit_queued)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.can_start = 1'b1;
                    state_next    = stat.head_is_u ? S_CAN_FIX : S_CAN_WALK;
                end
            end
            S_CAN_WALK:
            begin
                if (stat.cur_valid && !stat.link_hit)
                begin
                    cmd.can_step = 1'b1;
                end
                else
                begin
                    cmd.can_link = stat.cur_valid;
                    state_next   = S_CAN_FIX;
                end
            end
            S_CAN_FIX:
            begin
                cmd.sel     = SEL_NX;
                cmd.can_fix = 1'b1;
                state_next  = S_IDLE;
            end
            S_QRY_WALK:
            begin
                if (stat.unit_queued && stat.cur_valid)
                begin
                    cmd.qry_step = 1'b1;
                    if (stat.qry_hit)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.qry_miss = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_ADV_START:
            begin
                cmd.sel = SEL_HEAD;
                if (!stat.head_valid)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.adv_start = 1'b1;
                    state_next    = stat.adv_hold ? S_IDLE : S_ADV_FIRE;
                end
            end
            S_ADV_FIRE:
            begin
                cmd.sel      = SEL_NHEAD;
                cmd.adv_fire = 1'b1;
                if (stat.adv_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

`default_nettype wire

// ===== sv/dtq_datapath.sv =====
// Datapath: link and delta stores, walk registers and the result registers.
`default_nettype none

module dtq_datapath
    import dtq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    input  wire logic [IDX_BITS-1:0]   unit_id,
    input  wire logic [DELAY_BITS-1:0] delay,
    input  wire logic [TICK_BITS-1:0]  elapsed_ticks,
    output stat_t                      stat,
    output logic                       result_valid,
    output logic [IDX_BITS-1:0]        unit_out,
    output logic                       fired,
    output logic                       is_active,
    output logic [UNTIL_BITS-1:0]      time_until,
    output logic                       last
);

    logic [UNIT_BITS-1:0] link_reg [NUM_UNITS];
    logic [TIME_BITS-1:0] delta_reg [NUM_UNITS];
    logic [NUM_UNITS-1:0] queued_reg;
    logic [UNIT_BITS-1:0] head_reg;

    logic [IDX_BITS-1:0]  u_reg;
    logic [TIME_BITS-1:0] d_reg;
    logic [TICK_BITS-1:0] e_reg;
    logic [TICK_BITS-1:0] o_reg;
    logic [UNIT_BITS-1:0] cur_reg;
    logic [UNIT_BITS-1:0] prev_reg;
    logic [CNT_BITS-1:0]  n_reg;
    logic [ACC_BITS-1:0]  accum_reg;
    logic [TIME_BITS-1:0] newd_reg;
    logic [UNIT_BITS-1:0] nx_reg;
    logic [TIME_BITS-1:0] du_reg;

    logic                  valid_reg;
    logic [IDX_BITS-1:0]   unit_reg;
    logic                  fired_reg;
    logic                  active_reg;
    logic [UNTIL_BITS-1:0] until_reg;
    logic                  last_reg;

    logic [UNIT_BITS-1:0] u_ext;
    logic [UNIT_BITS-1:0] link_addr;
    logic [UNIT_BITS-1:0] link_rd;
    logic [UNIT_BITS-1:0] delta_addr;
    logic [TIME_BITS-1:0] delta_rd;
    logic [ACC_BITS-1:0]  walk_sum;
    logic [ACC_BITS-1:0]  until_sum;
    logic [TIME_BITS-1:0] ins_delta;
    logic                 nh_valid;
    logic [TICK_BITS-1:0] o_rem;

    logic                 lw_en;
    logic [UNIT_BITS-1:0] lw_addr;
    logic [UNIT_BITS-1:0] lw_data;
    logic                 dw_en;
    logic [UNIT_BITS-1:0] dw_addr;
    logic [TIME_BITS-1:0] dw_data;

    assign u_ext = {1'b0, u_reg};

    always_comb
    begin
        case (cmd.sel)
            SEL_NHEAD: link_addr = head_reg;
            SEL_UNIT:  link_addr = u_ext;
            default:   link_addr = cur_reg;
        endcase
    end

    assign link_rd = link_reg[link_addr[IDX_BITS-1:0]];

    always_comb
    begin
        case (cmd.sel)
            SEL_HEAD:  delta_addr = head_reg;
            SEL_NHEAD: delta_addr = link_rd;
            SEL_UNIT:  delta_addr = u_ext;
            SEL_NX:    delta_addr = nx_reg;
            default:   delta_addr = cur_reg;
        endcase
    end

    assign delta_rd  = delta_reg[delta_addr[IDX_BITS-1:0]];
    assign walk_sum  = accum_reg + ACC_BITS'(delta_rd);
    assign until_sum = walk_sum + ACC_BITS'(1);
    assign ins_delta = TIME_BITS'(ACC_BITS'(d_reg) - accum_reg);
    assign nh_valid  = (link_rd < END_MARK);
    assign o_rem     = TICK_BITS'(o_reg - TICK_BITS'(delta_rd));

    always_comb
    begin
        stat.unit_queued = queued_reg[u_reg];
        stat.head_valid  = (head_reg < END_MARK);
        stat.head_is_u   = (head_reg == u_ext);
        stat.cur_valid   = (cur_reg < END_MARK) && (n_reg < CNT_LIMIT);
        stat.act_stop    = (ACC_BITS'(d_reg) < walk_sum);
        stat.link_hit    = (link_rd == u_ext);
        stat.qry_hit     = (cur_reg == u_ext);
        stat.adv_hold    = (delta_rd > TIME_BITS'(e_reg));
        stat.adv_last    = !nh_valid || (delta_rd > TIME_BITS'(o_reg));
    end

    always_comb
    begin
        lw_en   = 1'b0;
        lw_addr = u_ext;
        lw_data = cur_reg;
        dw_en   = 1'b0;
        dw_addr = u_ext;
        dw_data = ins_delta;
        if (cmd.act_link)
        begin
            lw_en = 1'b1;
            dw_en = 1'b1;
        end
        if (cmd.act_fix)
        begin
            lw_en   = (prev_reg < END_MARK);
            lw_addr = prev_reg;
            lw_data = u_ext;
            dw_en   = (cur_reg < END_MARK);
            dw_addr = cur_reg;
            dw_data = delta_rd - newd_reg;
        end
        if (cmd.can_link)
        begin
            lw_en   = 1'b1;
            lw_addr = cur_reg;
            lw_data = nx_reg;
        end
        if (cmd.can_fix)
        begin
            dw_en   = (nx_reg < END_MARK);
            dw_addr = nx_reg;
            dw_data = delta_rd + du_reg;
        end
        if (cmd.adv_start)
        begin
            dw_en   = stat.adv_hold;
            dw_addr = head_reg;
            dw_data = delta_rd - TIME_BITS'(e_reg);
        end
        if (cmd.adv_fire)
        begin
            dw_en   = stat.adv_last && nh_valid;
            dw_addr = link_rd;
            dw_data = delta_rd - TIME_BITS'(o_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (lw_en)
        begin
            link_reg[lw_addr[IDX_BITS-1:0]] <= lw_data;
        end
        if (dw_en)
        begin
            delta_reg[dw_addr[IDX_BITS-1:0]] <= dw_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            queued_reg <= '0;
            head_reg   <= END_MARK;
            valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= cmd.qry_miss || (cmd.qry_step && stat.qry_hit) || cmd.adv_fire;
            if (cmd.act_link)
            begin
                queued_reg[u_reg] <= 1'b1;
                if (prev_reg == END_MARK)
                begin
                    head_reg <= u_ext;
                end
            end
            if (cmd.can_start && stat.head_is_u)
            begin
                head_reg <= link_rd;
            end
            if (cmd.can_fix)
            begin
                queued_reg[u_reg] <= 1'b0;
            end
            if (cmd.adv_fire)
            begin
                queued_reg[head_reg[IDX_BITS-1:0]] <= 1'b0;
                head_reg <= link_rd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            u_reg     <= unit_id;
            d_reg     <= TIME_BITS'(delay);
            e_reg     <= elapsed_ticks;
            cur_reg   <= head_reg;
            prev_reg  <= END_MARK;
            n_reg     <= '0;
            accum_reg <= '0;
        end
        if (cmd.act_step || cmd.qry_step)
        begin
            accum_reg <= walk_sum;
            cur_reg   <= link_rd;
            n_reg     <= n_reg + CNT_BITS'(1);
        end
        if (cmd.act_step)
        begin
            prev_reg <= cur_reg;
        end
        if (cmd.act_link)
        begin
            newd_reg <= ins_delta;
        end
        if (cmd.can_start)
        begin
            nx_reg  <= link_rd;
            du_reg  <= delta_rd;
            cur_reg <= head_reg;
            n_reg   <= '0;
        end
        if (cmd.can_step)
        begin
            cur_reg <= link_rd;
            n_reg   <= n_reg + CNT_BITS'(1);
        end
        if (cmd.adv_start)
        begin
            o_reg <= TICK_BITS'(TIME_BITS'(e_reg) - delta_rd);
        end
        if (cmd.adv_fire && !stat.adv_last)
        begin
            o_reg <= o_rem;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.qry_miss)
        begin
            unit_reg   <= u_reg;
            fired_reg  <= 1'b0;
            active_reg <= 1'b0;
            until_reg  <= '0;
            last_reg   <= 1'b1;
        end
        else if (cmd.qry_step)
        begin
            unit_reg   <= u_reg;
            fired_reg  <= 1'b0;
            active_reg <= 1'b1;
            until_reg  <= (until_sum > ACC_BITS'(UNTIL_MAX)) ? UNTIL_MAX
                                                              : UNTIL_BITS'(until_sum);
            last_reg   <= 1'b1;
        end
        else if (cmd.adv_fire)
        begin
            unit_reg   <= head_reg[IDX_BITS-1:0];
            fired_reg  <= 1'b1;
            active_reg <= 1'b0;
            until_reg  <= '0;
            last_reg   <= stat.adv_last;
        end
    end

    assign result_valid = valid_reg;
    assign unit_out     = unit_reg;
    assign fired        = fired_reg;
    assign is_active    = active_reg;
    assign time_until   = until_reg;
    assign last         = last_reg;

endmodule

`default_nettype wire

// ===== sv/delta_event_timer_queue_top.sv =====
// Top level of the delta-list timer queue: controller plus datapath.
//
// Command channel: a word (opcode, unit_id, delay, elapsed_ticks) is taken at
// a rising edge with start high and busy low. busy stays high while the word
// is worked on; the list is walked one entry per cycle.
// Result channel: result_valid marks each result for exactly one cycle; the
// receiver takes it at the end of that cycle and cannot hold it off.
// Per command word:
//   activate : no change if the unit is already queued
//   cancel   : skips the walk when the unit heads the list; no change if not queued
//   query    : walks the list until it reaches the unit (no walk if not queued); one result,
//              valid the cycle after the last walk step
//   advance  : no result if nothing falls due, else one result per fired unit,
//              one result per cycle, last set on the final one
// The walk rate is set by one read of the link and delta stores per cycle.
// Reset empties the queue and leaves the block idle with no result pending.
`default_nettype none

module delta_event_timer_queue_top
    import dtq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            opcode,
    input  wire logic [IDX_BITS-1:0]   unit_id,
    input  wire logic [DELAY_BITS-1:0] delay,
    input  wire logic [TICK_BITS-1:0]  elapsed_ticks,
    output logic                       result_valid,
    output logic [IDX_BITS-1:0]        unit_out,
    output logic                       fired,
    output logic                       is_active,
    output logic [UNTIL_BITS-1:0]      time_until,
    output logic                       last
);

    cmd_t  cmd;
    stat_t stat;

    dtq_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    dtq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .unit_id       (unit_id),
        .delay         (delay),
        .elapsed_ticks (elapsed_ticks),
        .stat          (stat),
        .result_valid  (result_valid),
        .unit_out      (unit_out),
        .fired         (fired),
        .is_active     (is_active),
        .time_until    (time_until),
        .last          (last)
    );

endmodule

`default_nettype wire
